// ===== rtl/quadratic_bezier_segment_sampler_macros.svh =====
// ---------------------------------------------------------------------------
// Quadratic Bezier segment sampler assertion macros
// Shared assertion shorthands, clocked on i_clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_BEZIER_SEGMENT_SAMPLER_MACROS_SVH
`define QUADRATIC_BEZIER_SEGMENT_SAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QBSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: same cycle");

// The consequent must hold in the cycle after the antecedent.
`define QBSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next cycle");

`endif

// ===== rtl/qbss_pkg.sv =====
// ---------------------------------------------------------------------------
// Quadratic Bezier segment sampler package
// Shared types and fixed constants of the sampler.
// ---------------------------------------------------------------------------
package qbss_pkg;

    localparam int COORD_W = 32;
    localparam int CTRL_W  = 34;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int INTV_W  = 6;

    localparam logic [INTV_W-1:0]        INTERVALS_RST = 6'd20;
    localparam logic signed [COORD_W-1:0] CTRL_OFFSET_RST = 32'sd13107;
    localparam logic [COORD_W-1:0]        COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0]        COORD_MIN = 32'h8000_0000;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_INTERVALS   = 2'd0;
    localparam logic [1:0] REG_T_STEP      = 2'd1;
    localparam logic [1:0] REG_CTRL_OFFSET = 2'd2;

    // One segment: start point, control point and end point.
    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [CTRL_W-1:0]  x1;
        logic signed [CTRL_W-1:0]  y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } t_seg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_back_state;

endpackage

// ===== rtl/quadratic_bezier_segment_sampler.sv =====
// A segment's first point passes the queue, the segment register, stages s1 to s4 and the
// output register. Throughput, unless stalled: one point per cycle, intervals+1 points per
// segment (21 at reset values), the back-end t sequencer issuing one sample a cycle into a
// five-stage evaluation pipeline. A two-entry segment queue lets waypoints enter while earlier
// segments are still sampled. Reset (synchronous, active low) clears the stored waypoint,
// queue and pipeline and loads intervals = 20, t_step = 0.05 and control_offset = 13107.
// ---------------------------------------------------------------------------
// Quadratic Bezier segment sampler
// Turns a stream of waypoints into sampled quadratic Bezier curve points.
// ---------------------------------------------------------------------------
`include "quadratic_bezier_segment_sampler_macros.svh"

module quadratic_bezier_segment_sampler #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // waypoint channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [qbss_pkg::COORD_W-1:0]   i_way_x,
    input  logic signed [qbss_pkg::COORD_W-1:0]   i_way_y,
    input  logic                                  i_path_start,
    // curve point channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [qbss_pkg::COORD_W-1:0]   o_curve_x,
    output logic signed [qbss_pkg::COORD_W-1:0]   o_curve_y,
    output logic                                  o_segment_last,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [qbss_pkg::ADDR_W-1:0]           paddr,
    input  logic [qbss_pkg::DATA_W-1:0]           pwdata,
    output logic [qbss_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);

    // t_step of 0.05 in units of 2^-T_FRAC_BITS, rounded to nearest.
    localparam logic [T_FRAC_BITS:0] T_STEP_RST =
        (T_FRAC_BITS+1)'(((1 << T_FRAC_BITS) * 5 + 50) / 100);

    logic [qbss_pkg::INTV_W-1:0]          r_intervals;
    logic [T_FRAC_BITS:0]                 r_t_step;
    logic signed [qbss_pkg::COORD_W-1:0]  r_control_offset;
    logic                                 cfg_wr;

    logic                                 push;
    logic                                 pop;
    qbss_pkg::t_seg                       front_seg;
    qbss_pkg::t_seg                       queue_seg;
    qbss_pkg::t_q_status                  q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intervals      <= qbss_pkg::INTERVALS_RST;
            r_t_step         <= T_STEP_RST;
            r_control_offset <= qbss_pkg::CTRL_OFFSET_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                qbss_pkg::REG_INTERVALS:   r_intervals      <= pwdata[qbss_pkg::INTV_W-1:0];
                qbss_pkg::REG_T_STEP:      r_t_step         <= pwdata[T_FRAC_BITS:0];
                qbss_pkg::REG_CTRL_OFFSET: r_control_offset <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            qbss_pkg::REG_INTERVALS:   prdata = qbss_pkg::DATA_W'(r_intervals);
            qbss_pkg::REG_T_STEP:      prdata = qbss_pkg::DATA_W'(r_t_step);
            qbss_pkg::REG_CTRL_OFFSET: prdata = r_control_offset;
            default:                   prdata = '0;
        endcase
    end

    qbss_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_way_x          (i_way_x),
        .i_way_y          (i_way_y),
        .i_path_start     (i_path_start),
        .i_control_offset (r_control_offset),
        .i_q_stat         (q_stat),
        .o_push           (push),
        .o_seg            (front_seg)
    );

    qbss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (front_seg),
        .i_pop   (pop),
        .o_seg   (queue_seg),
        .o_stat  (q_stat)
    );

    qbss_back #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_intervals    (r_intervals),
        .i_t_step       (r_t_step),
        .i_seg          (queue_seg),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_curve_x      (o_curve_x),
        .o_curve_y      (o_curve_y),
        .o_segment_last (o_segment_last)
    );

    `QBSS_ASSERT_NOW(a_no_pop_when_empty, pop, !q_stat.empty)
    `QBSS_ASSERT_NOW(a_no_push_when_full, push, !q_stat.full)
    `QBSS_ASSERT_NEXT(a_pop_frees_slot, pop && !push && q_stat.full, !q_stat.full)

endmodule

// ===== rtl/qbss_front.sv =====
// ---------------------------------------------------------------------------
// Sampler front end
// Accepts waypoints, keeps the previous one and builds segment descriptors.
// ---------------------------------------------------------------------------
module qbss_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [qbss_pkg::COORD_W-1:0]   i_way_x,
    input  logic signed [qbss_pkg::COORD_W-1:0]   i_way_y,
    input  logic                                  i_path_start,
    input  logic signed [qbss_pkg::COORD_W-1:0]   i_control_offset,
    input  qbss_pkg::t_q_status                   i_q_stat,
    output logic                                  o_push,
    output qbss_pkg::t_seg                        o_seg
);

    logic signed [qbss_pkg::COORD_W-1:0] r_prev_x;
    logic signed [qbss_pkg::COORD_W-1:0] r_prev_y;
    logic                                r_have_prev;
    logic                                accept;
    logic signed [qbss_pkg::COORD_W:0]   sum_x;
    logic signed [qbss_pkg::COORD_W:0]   sum_y;
    logic signed [qbss_pkg::COORD_W:0]   mid_x;
    logic signed [qbss_pkg::COORD_W:0]   mid_y;
    logic signed [qbss_pkg::CTRL_W-1:0]  off_ext;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    // A waypoint without a stored predecessor only starts a path.
    assign o_push  = accept && !i_path_start && r_have_prev;

    always_comb begin
        sum_x   = {r_prev_x[31], r_prev_x} + {i_way_x[31], i_way_x};
        sum_y   = {r_prev_y[31], r_prev_y} + {i_way_y[31], i_way_y};
        mid_x   = sum_x >>> 1;
        mid_y   = sum_y >>> 1;
        off_ext = {{2{i_control_offset[31]}}, i_control_offset};
        o_seg.x0 = r_prev_x;
        o_seg.y0 = r_prev_y;
        o_seg.x1 = {mid_x[32], mid_x} + off_ext;
        o_seg.y1 = {mid_y[32], mid_y} + off_ext;
        o_seg.x2 = i_way_x;
        o_seg.y2 = i_way_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
        end else if (accept) begin
            r_prev_x    <= i_way_x;
            r_prev_y    <= i_way_y;
            r_have_prev <= 1'b1;
        end
    end

endmodule

// ===== rtl/qbss_queue.sv =====
// ---------------------------------------------------------------------------
// Segment queue
// Two-entry queue of segment descriptors between front and back end.
// ---------------------------------------------------------------------------
module qbss_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  qbss_pkg::t_seg       i_seg,
    input  logic                 i_pop,
    output qbss_pkg::t_seg       o_seg,
    output qbss_pkg::t_q_status  o_stat
);

    qbss_pkg::t_seg r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_seg        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/qbss_back.sv =====
// ---------------------------------------------------------------------------
// Sampler back end
// Steps t over one segment and evaluates the curve in a five-stage pipeline.
// ---------------------------------------------------------------------------
module qbss_back #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [qbss_pkg::INTV_W-1:0]           i_intervals,
    input  logic [T_FRAC_BITS:0]                  i_t_step,
    input  qbss_pkg::t_seg                        i_seg,
    input  qbss_pkg::t_q_status                   i_q_stat,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [qbss_pkg::COORD_W-1:0]   o_curve_x,
    output logic signed [qbss_pkg::COORD_W-1:0]   o_curve_y,
    output logic                                  o_segment_last
);

    localparam int F      = T_FRAC_BITS;
    localparam int TACC_W = F + 7;
    localparam int PROD_W = F + 36;
    localparam int SUM_W  = F + 37;
    localparam int SH_W   = SUM_W - F;
    localparam logic [TACC_W-1:0] TACC_ONE = TACC_W'(1 << F);
    localparam logic [F:0]        T_ONE    = (F+1)'(1 << F);

    qbss_pkg::t_back_state          r_state;
    qbss_pkg::t_back_state          n_state;
    qbss_pkg::t_seg                 r_seg;
    qbss_pkg::t_seg                 n_seg;
    logic [qbss_pkg::INTV_W-1:0]    r_k;
    logic [qbss_pkg::INTV_W-1:0]    n_k;
    logic [TACC_W-1:0]              r_tacc;
    logic [TACC_W-1:0]              n_tacc;

    logic                           adv;
    logic                           is_last;
    logic [F:0]                     t_cur;

    logic                           r_s1_valid;
    logic                           r_s1_last;
    logic [F:0]                     r_s1_t;
    qbss_pkg::t_seg                 r_s1_seg;

    logic                           r_s2_valid;
    logic                           r_s2_last;
    logic [F:0]                     r_s2_uu;
    logic [F:0]                     r_s2_ut2;
    logic [F:0]                     r_s2_tt;
    qbss_pkg::t_seg                 r_s2_seg;

    logic                           r_s3_valid;
    logic                           r_s3_last;
    logic signed [PROD_W-1:0]       r_s3_px0;
    logic signed [PROD_W-1:0]       r_s3_px1;
    logic signed [PROD_W-1:0]       r_s3_px2;
    logic signed [PROD_W-1:0]       r_s3_py0;
    logic signed [PROD_W-1:0]       r_s3_py1;
    logic signed [PROD_W-1:0]       r_s3_py2;

    logic                           r_s4_valid;
    logic                           r_s4_last;
    logic signed [SUM_W-1:0]        r_s4_sum_x;
    logic signed [SUM_W-1:0]        r_s4_sum_y;

    logic                           r_o_valid;
    logic                           r_o_last;
    logic signed [qbss_pkg::COORD_W-1:0] r_o_x;
    logic signed [qbss_pkg::COORD_W-1:0] r_o_y;

    logic [F:0]                     u_cur;
    logic [2*F+1:0]                 uu_full;
    logic [2*F+1:0]                 ut_full;
    logic [2*F+1:0]                 tt_full;

    function automatic logic signed [PROD_W-1:0] mul_w(
        input logic [F:0]                        w,
        input logic signed [qbss_pkg::CTRL_W-1:0] c
    );
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = $signed({{(PROD_W-F-1){1'b0}}, w});
        b = {{(PROD_W-qbss_pkg::CTRL_W){c[qbss_pkg::CTRL_W-1]}}, c};
        return a * b;
    endfunction

    function automatic logic signed [qbss_pkg::CTRL_W-1:0] ext_c(
        input logic signed [qbss_pkg::COORD_W-1:0] v
    );
        return {{(qbss_pkg::CTRL_W-qbss_pkg::COORD_W){v[qbss_pkg::COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_s(
        input logic signed [PROD_W-1:0] v
    );
        return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    // Floor division by 2^F is the arithmetic shift; then clamp to 32 bits.
    function automatic logic signed [qbss_pkg::COORD_W-1:0] sat_shift(
        input logic signed [SUM_W-1:0] s
    );
        logic [SH_W-1:0] v;
        logic            fits;
        v    = s[SUM_W-1:F];
        fits = (&v[SH_W-1:qbss_pkg::COORD_W-1]) || !(|v[SH_W-1:qbss_pkg::COORD_W-1]);
        if (fits) begin
            return v[qbss_pkg::COORD_W-1:0];
        end else if (v[SH_W-1]) begin
            return qbss_pkg::COORD_MIN;
        end else begin
            return qbss_pkg::COORD_MAX;
        end
    endfunction

    // The whole pipeline moves together whenever the output register can load.
    assign adv     = !r_o_valid || !i_stall;
    assign is_last = (r_k == i_intervals);
    assign t_cur   = (is_last || (r_tacc > TACC_ONE)) ? T_ONE : r_tacc[F:0];

    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_k     = r_k;
        n_tacc  = r_tacc;
        o_pop   = 1'b0;
        case (r_state)
            qbss_pkg::ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_seg   = i_seg;
                    n_k     = '0;
                    n_tacc  = '0;
                    n_state = qbss_pkg::ST_RUN;
                end
            end
            qbss_pkg::ST_RUN: begin
                if (adv) begin
                    if (is_last) begin
                        if (!i_q_stat.empty) begin
                            o_pop  = 1'b1;
                            n_seg  = i_seg;
                            n_k    = '0;
                            n_tacc = '0;
                        end else begin
                            n_state = qbss_pkg::ST_IDLE;
                        end
                    end else begin
                        n_k    = r_k + 1'b1;
                        n_tacc = r_tacc + {{(TACC_W-F-1){1'b0}}, i_t_step};
                    end
                end
            end
            default: begin
                n_state = qbss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qbss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg  <= n_seg;
        r_k    <= n_k;
        r_tacc <= n_tacc;
    end

    always_comb begin
        u_cur   = T_ONE - r_s1_t;
        uu_full = {{(F+1){1'b0}}, u_cur} * {{(F+1){1'b0}}, u_cur};
        ut_full = {{(F+1){1'b0}}, u_cur} * {{(F+1){1'b0}}, r_s1_t};
        tt_full = {{(F+1){1'b0}}, r_s1_t} * {{(F+1){1'b0}}, r_s1_t};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= (r_state == qbss_pkg::ST_RUN);
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_o_valid  <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_t    <= t_cur;
            r_s1_last <= is_last;
            r_s1_seg  <= r_seg;

            // The factor two of the middle weight is one less bit of shift.
            r_s2_uu   <= uu_full[2*F:F];
            r_s2_ut2  <= ut_full[2*F-1:F-1];
            r_s2_tt   <= tt_full[2*F:F];
            r_s2_last <= r_s1_last;
            r_s2_seg  <= r_s1_seg;

            r_s3_px0  <= mul_w(r_s2_uu, ext_c(r_s2_seg.x0));
            r_s3_px1  <= mul_w(r_s2_ut2, r_s2_seg.x1);
            r_s3_px2  <= mul_w(r_s2_tt, ext_c(r_s2_seg.x2));
            r_s3_py0  <= mul_w(r_s2_uu, ext_c(r_s2_seg.y0));
            r_s3_py1  <= mul_w(r_s2_ut2, r_s2_seg.y1);
            r_s3_py2  <= mul_w(r_s2_tt, ext_c(r_s2_seg.y2));
            r_s3_last <= r_s2_last;

            r_s4_sum_x <= ext_s(r_s3_px0) + ext_s(r_s3_px1) + ext_s(r_s3_px2);
            r_s4_sum_y <= ext_s(r_s3_py0) + ext_s(r_s3_py1) + ext_s(r_s3_py2);
            r_s4_last  <= r_s3_last;

            r_o_x    <= sat_shift(r_s4_sum_x);
            r_o_y    <= sat_shift(r_s4_sum_y);
            r_o_last <= r_s4_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_curve_x      = r_o_x;
    assign o_curve_y      = r_o_y;
    assign o_segment_last = r_o_last;

endmodule

// ===== tb/quadratic_bezier_segment_sampler_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Quadratic Bezier segment sampler testbench
// Streams waypoints into the sampler under several register settings and
// handshake idling patterns, predicts every curve point in software and
// compares each point leaving the block against the oldest prediction.
// ---------------------------------------------------------------------------

class curve_checker;
    localparam int     T_FRAC     = 16;
    localparam longint T_ONE      = longint'(1) << T_FRAC;
    localparam int     T_STEP_RST = 3277;

    typedef struct {
        logic signed [qbss_pkg::COORD_W-1:0] x;
        logic signed [qbss_pkg::COORD_W-1:0] y;
        logic                                last;
    } t_point;

    t_point pending_points[$];
    int     errors;

    // Register copies and the stored end point of the previous segment.
    int     intervals;
    int     t_step;
    longint ctrl_offset;
    longint prev_x;
    longint prev_y;
    bit     have_prev;

    function new();
        errors      = 0;
        intervals   = qbss_pkg::INTERVALS_RST;
        t_step      = T_STEP_RST;
        ctrl_offset = qbss_pkg::CTRL_OFFSET_RST;
        prev_x      = 0;
        prev_y      = 0;
        have_prev   = 0;
    endfunction

    task report(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    function void write_reg(logic [1:0] idx, logic [qbss_pkg::DATA_W-1:0] val);
        case (idx)
            qbss_pkg::REG_INTERVALS: begin
                intervals = val[qbss_pkg::INTV_W-1:0];
            end
            qbss_pkg::REG_T_STEP: begin
                t_step = val[16:0];
            end
            qbss_pkg::REG_CTRL_OFFSET: begin
                ctrl_offset = longint'(signed'(val));
            end
            default: begin
            end
        endcase
    endfunction

    function logic signed [qbss_pkg::COORD_W-1:0] saturate(longint v);
        longint hi;
        longint lo;
        hi = longint'(qbss_pkg::COORD_MAX);
        lo = longint'(signed'(qbss_pkg::COORD_MIN));
        if (v > hi) begin
            return qbss_pkg::COORD_MAX;
        end
        if (v < lo) begin
            return qbss_pkg::COORD_MIN;
        end
        return v[qbss_pkg::COORD_W-1:0];
    endfunction

    // Weighted sum of the three points, floored back to Q16.16.
    function longint blend(longint uu, longint ut2, longint tt,
                           longint p0, longint p1, longint p2);
        return (uu * p0 + ut2 * p1 + tt * p2) >>> T_FRAC;
    endfunction

    function void take_waypoint(logic signed [qbss_pkg::COORD_W-1:0] wx,
                                logic signed [qbss_pkg::COORD_W-1:0] wy, logic start);
        longint x0, y0, x1, y1, x2, y2;
        longint t, u, uu, ut2, tt;
        t_point p;
        x2 = wx;
        y2 = wy;
        if (!start && have_prev) begin
            x0 = prev_x;
            y0 = prev_y;
            x1 = ((x0 + x2) >>> 1) + ctrl_offset;
            y1 = ((y0 + y2) >>> 1) + ctrl_offset;
            for (int k = 0; k <= intervals; k++) begin
                t = longint'(k) * t_step;
                // The final sample is pinned to t = 1, and overshoot clamps there too.
                if (t > T_ONE || k == intervals) begin
                    t = T_ONE;
                end
                u   = T_ONE - t;
                uu  = (u * u) >>> T_FRAC;
                ut2 = (2 * u * t) >>> T_FRAC;
                tt  = (t * t) >>> T_FRAC;
                p.x    = saturate(blend(uu, ut2, tt, x0, x1, x2));
                p.y    = saturate(blend(uu, ut2, tt, y0, y1, y2));
                p.last = (k == intervals);
                pending_points.insert(pending_points.size(), p);
            end
        end
        prev_x    = x2;
        prev_y    = y2;
        have_prev = 1;
    endfunction

    task check_point(logic signed [qbss_pkg::COORD_W-1:0] x,
                     logic signed [qbss_pkg::COORD_W-1:0] y, logic last);
        t_point want;
        if (pending_points.size() == 0) begin
            report($sformatf("unexpected point x=%0d y=%0d last=%0b", x, y, last));
            return;
        end
        want = pending_points.pop_front();
        if (x !== want.x) begin
            report($sformatf("curve_x got %0d want %0d", x, want.x));
        end
        if (y !== want.y) begin
            report($sformatf("curve_y got %0d want %0d", y, want.y));
        end
        if (last !== want.last) begin
            report($sformatf("segment_last got %0b want %0b", last, want.last));
        end
    endtask

    task finish();
        if (pending_points.size() != 0) begin
            report($sformatf("%0d points never arrived", pending_points.size()));
        end
    endtask
endclass

module quadratic_bezier_segment_sampler_tb;

    // Index with no register behind it; writes there must be dropped.
    localparam logic [1:0] REG_NONE = 2'd3;

    logic                                  i_clk          = 1'b0;
    logic                                  i_rst_n        = 1'b0;
    logic                                  i_valid        = 1'b0;
    logic                                  o_stall;
    logic signed [qbss_pkg::COORD_W-1:0]   i_way_x        = '0;
    logic signed [qbss_pkg::COORD_W-1:0]   i_way_y        = '0;
    logic                                  i_path_start   = 1'b0;
    logic                                  o_valid;
    logic                                  i_stall        = 1'b0;
    logic signed [qbss_pkg::COORD_W-1:0]   o_curve_x;
    logic signed [qbss_pkg::COORD_W-1:0]   o_curve_y;
    logic                                  o_segment_last;
    logic                                  psel           = 1'b0;
    logic                                  penable        = 1'b0;
    logic                                  pwrite         = 1'b0;
    logic [qbss_pkg::ADDR_W-1:0]           paddr          = '0;
    logic [qbss_pkg::DATA_W-1:0]           pwdata         = '0;
    logic [qbss_pkg::DATA_W-1:0]           prdata;
    logic                                  pready;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    curve_checker board = new();

    quadratic_bezier_segment_sampler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_way_x        (i_way_x),
        .i_way_y        (i_way_y),
        .i_path_start   (i_path_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_curve_x      (o_curve_x),
        .o_curve_y      (o_curve_y),
        .o_segment_last (o_segment_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // A word leaves the block at every edge where it is valid and not stalled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_point(o_curve_x, o_curve_y, o_segment_last);
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [qbss_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic send_waypoint(logic signed [qbss_pkg::COORD_W-1:0] x,
                                 logic signed [qbss_pkg::COORD_W-1:0] y, logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_way_x      <= x;
        i_way_y      <= y;
        i_path_start <= start;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.take_waypoint(x, y, start);
    endtask

    // Holds the sender off until every predicted point has come out, then lets
    // the pipeline settle past its latency.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_points.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [qbss_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return qbss_pkg::COORD_MAX;
            1:       return qbss_pkg::COORD_MIN;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    initial begin
        int intv;
        int step;
        logic [qbss_pkg::DATA_W-1:0] ofs;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at reset register values; the first has no predecessor.
        send_waypoint(32'sh0001_0000, 32'sh0002_0000, 1'b0);
        send_waypoint(32'sh0003_8000, 32'shFFFF_0000, 1'b0);
        send_waypoint(qbss_pkg::COORD_MAX, qbss_pkg::COORD_MIN, 1'b0);
        send_waypoint(qbss_pkg::COORD_MIN, qbss_pkg::COORD_MAX, 1'b0);
        send_waypoint(qbss_pkg::COORD_MAX, qbss_pkg::COORD_MAX, 1'b1);
        send_waypoint(qbss_pkg::COORD_MAX, qbss_pkg::COORD_MAX, 1'b0);
        send_waypoint(-32'sd1, -32'sd1, 1'b1);
        send_waypoint(32'sd0, 32'sd0, 1'b0);

        wait_drained();
        apb_write(REG_NONE, 32'hFFFF_FFFF);
        apb_write(qbss_pkg::REG_INTERVALS, 32'd0);
        send_waypoint(32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_waypoint(32'shFFFB_0000, 32'sh0007_0000, 1'b0);

        wait_drained();
        apb_write(qbss_pkg::REG_INTERVALS, 32'd8);
        apb_write(qbss_pkg::REG_T_STEP, 32'd0);
        send_waypoint(32'sh0010_0000, 32'shFFF0_0000, 1'b0);
        send_waypoint(32'sh0000_1234, 32'sh0020_0000, 1'b0);

        wait_drained();
        apb_write(qbss_pkg::REG_INTERVALS, 32'd63);
        apb_write(qbss_pkg::REG_T_STEP, 32'h1_FFFF);
        send_waypoint(32'sh0100_0000, 32'sh0000_0000, 1'b0);
        send_waypoint(32'shFF00_0000, 32'sh0300_0000, 1'b0);

        wait_drained();
        apb_write(qbss_pkg::REG_T_STEP, 32'd8192);
        apb_write(qbss_pkg::REG_CTRL_OFFSET, qbss_pkg::COORD_MIN);
        send_waypoint(qbss_pkg::COORD_MIN, qbss_pkg::COORD_MIN, 1'b1);
        send_waypoint(qbss_pkg::COORD_MIN, qbss_pkg::COORD_MIN, 1'b0);
        wait_drained();
        apb_write(qbss_pkg::REG_CTRL_OFFSET, qbss_pkg::COORD_MAX);
        send_waypoint(qbss_pkg::COORD_MAX, qbss_pkg::COORD_MAX, 1'b0);
        send_waypoint(32'sd0, 32'sd0, 1'b0);

        // Random words: mostly continuing paths, with an occasional restart.
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            case (ph)
                0: begin
                    intv = qbss_pkg::INTERVALS_RST;
                    step = 3277;
                    ofs  = qbss_pkg::CTRL_OFFSET_RST;
                end
                1: begin
                    intv = 63;
                    step = 1040;
                    ofs  = qbss_pkg::COORD_MIN;
                end
                2: begin
                    intv = 1;
                    step = 65536;
                    ofs  = 32'd0;
                end
                3: begin
                    intv = 63;
                    step = 32'h1_FFFF;
                    ofs  = qbss_pkg::COORD_MAX;
                end
                default: begin
                    intv = $urandom_range(0, 63);
                    if ($urandom_range(3) == 0) begin
                        step = $urandom_range(0, 32'h1_FFFF);
                    end else begin
                        step = (65536 + $urandom_range(0, 2047)) / (intv + 1);
                    end
                    ofs = ($urandom_range(1) == 0) ? $urandom
                                                   : $urandom_range(0, 32'h0004_0000);
                end
            endcase
            apb_write(qbss_pkg::REG_INTERVALS, intv);
            apb_write(qbss_pkg::REG_T_STEP, step);
            apb_write(qbss_pkg::REG_CTRL_OFFSET, ofs);
            for (int i = 0; i < 56; i++) begin
                if (ph == 0 && i == 28) begin
                    wait_drained();
                end
                send_waypoint(rand_coord(), rand_coord(), $urandom_range(7) == 0);
            end
        end

        wait_drained();
        board.finish();
        if (board.errors == 0) begin
            $display("quadratic_bezier_segment_sampler_tb: done, clean");
        end else begin
            $display("quadratic_bezier_segment_sampler_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("quadratic_bezier_segment_sampler_tb: done, errors");
        $finish;
    end
endmodule

// ===== quadratic_bezier_segment_sampler.f =====
+incdir+rtl
rtl/qbss_pkg.sv
rtl/qbss_front.sv
rtl/qbss_queue.sv
rtl/qbss_back.sv
rtl/quadratic_bezier_segment_sampler.sv
tb/quadratic_bezier_segment_sampler_tb.sv
